// File: hw/rtl/chte_pkg.sv
// chte_pkg: item types, commands and status codes for the chained hash table engine
// no dependencies
package chte_pkg;

  localparam logic [1:0] CMD_PUT = 2'd0;
  localparam logic [1:0] CMD_GET = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] value_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
  } rsp_t;

endpackage

// File: hw/rtl/chte_bucket_ram.sv
// chte_bucket_ram: bucket head memory with a registered read
// no dependencies; contents are cleared by the top level after reset
module chte_bucket_ram #(
  parameter int NumBuckets = 64,
  parameter int LinkW = 9,
  parameter int BW = 6
) (
  input  logic             clk,
  input  logic [BW-1:0]    rd_addr,
  input  logic             rd_en,
  output logic [LinkW-1:0] rd_data,
  input  logic             wr_en,
  input  logic [BW-1:0]    wr_addr,
  input  logic [LinkW-1:0] wr_data
);

  logic [LinkW-1:0] mem [NumBuckets];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/chte_node_ram.sv
// chte_node_ram: node pool memory holding key, value and next link per node
// no dependencies; one write port, one read port, registered read
module chte_node_ram #(
  parameter int PoolNodes = 256,
  parameter int LinkW = 9,
  parameter int NW = 8
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [NW-1:0]          rd_addr,
  output logic [64+LinkW-1:0]    rd_data,
  input  logic                   wr_en,
  input  logic [NW-1:0]          wr_addr,
  input  logic [64+LinkW-1:0]    wr_data
);

  logic [64+LinkW-1:0] mem [PoolNodes];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/chained_hash_table_engine_top.sv
// chained_hash_table_engine_top: separate chaining hash table on two synchronous memories
// a request hashes its key, reads the bucket head, then reads chain nodes in turn; a put on an
// empty bucket writes the node and the head, on a non-empty bucket it then links the old tail,
// and a reused freed node is first popped off the free list; a remove hit unlinks and frees the
// node; one item at a time, the next item is taken in the cycle after the result leaves
// reset: synchronous rst, then in_stall high while bucket heads clear
// uses chte_pkg, chte_bucket_ram, chte_node_ram
module chained_hash_table_engine_top
  import chte_pkg::*;
#(
  parameter int NUM_BUCKETS = 64,
  parameter int POOL_NODES = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int NW = $clog2(POOL_NODES);
  localparam int LinkW = $clog2(POOL_NODES + 1);
  localparam logic [LinkW-1:0] LinkNull = LinkW'(POOL_NODES);
  localparam logic [BW-1:0] LastBkt = BW'(NUM_BUCKETS - 1);
  localparam bit BktPow2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_HASH     = 4'd2;
  localparam logic [3:0] S_HEAD     = 4'd3;
  localparam logic [3:0] S_POP_RD   = 4'd4;
  localparam logic [3:0] S_POP_DAT  = 4'd5;
  localparam logic [3:0] S_WALK_RD  = 4'd6;
  localparam logic [3:0] S_WALK_DAT = 4'd7;
  localparam logic [3:0] S_PUT_NEW  = 4'd8;
  localparam logic [3:0] S_PUT_LINK = 4'd9;
  localparam logic [3:0] S_REM_PREV = 4'd10;
  localparam logic [3:0] S_REM_FREE = 4'd11;
  localparam logic [3:0] S_OUT      = 4'd12;

  logic [3:0]       state;
  req_t             req;
  logic [BW-1:0]    bkt, clr_idx;
  logic [LinkW-1:0] cur, prev, free_head, fresh, alloc;
  logic [31:0]      prev_key, prev_val;
  logic             accept;

  logic             hash_done;
  logic [BW-1:0]    hash_bkt;

  logic             bh_we;
  logic [BW-1:0]    bh_wa;
  logic [LinkW-1:0] bh_q, bh_wd;
  logic             nd_rd, nd_we;
  logic [NW-1:0]    nd_ra, nd_wa;
  logic [64+LinkW-1:0] nd_q, nd_wd;
  logic [31:0]      n_key, n_val;
  logic [LinkW-1:0] n_next;

  assign accept = in_valid && !in_stall;

  // bucket from key: low bits for power-of-two counts, else a registered reciprocal multiply and remainder
  generate
    if (BktPow2) begin : g_mask
      assign hash_bkt = BW'(in_data.key & 32'(NUM_BUCKETS - 1));
      assign hash_done = accept;
    end else begin : g_recip
      localparam int RecipShift = $clog2(NUM_BUCKETS);
      localparam logic [64:0] Recip =
        ((65'd1 << (32 + RecipShift)) + 65'(NUM_BUCKETS) - 65'd1) / 65'(NUM_BUCKETS);
      logic [31:0]   key1, key2, quo;
      logic [47:0]   p_lo;
      logic [48:0]   p_hi;
      logic [64:0]   prod;
      logic [BW-1:0] rem;
      logic [2:0]    vld;

      assign prod = {p_hi, 16'd0} + 65'(p_lo);

      always_ff @(posedge clk) begin
        if (rst) begin
          vld <= '0;
        end else begin
          vld <= {vld[1:0], accept};
        end
        key1 <= in_data.key;
        p_lo <= 48'(in_data.key) * 48'(Recip[15:0]);
        p_hi <= 49'(in_data.key) * 49'(Recip[32:16]);
        key2 <= key1;
        quo <= 32'(prod >> (32 + RecipShift));
        rem <= BW'(key2 - (quo * 32'(NUM_BUCKETS)));
      end

      assign hash_bkt = rem;
      assign hash_done = vld[2];
    end
  endgenerate

  chte_bucket_ram #(.NumBuckets(NUM_BUCKETS), .LinkW(LinkW), .BW(BW)) u_bkt (
    .clk,
    .rd_addr (hash_bkt), .rd_en (hash_done), .rd_data (bh_q),
    .wr_en (bh_we), .wr_addr (bh_wa), .wr_data (bh_wd)
  );

  chte_node_ram #(.PoolNodes(POOL_NODES), .LinkW(LinkW), .NW(NW)) u_node (
    .clk,
    .rd_en (nd_rd), .rd_addr (nd_ra), .rd_data (nd_q),
    .wr_en (nd_we), .wr_addr (nd_wa), .wr_data (nd_wd)
  );

  assign {n_key, n_val, n_next} = nd_q;
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    bh_we = 1'b0;
    bh_wa = bkt;
    bh_wd = LinkNull;
    nd_rd = 1'b0;
    nd_ra = cur[NW-1:0];
    nd_we = 1'b0;
    nd_wa = cur[NW-1:0];
    nd_wd = {n_key, n_val, n_next};
    case (state)
      S_CLR: begin
        bh_we = 1'b1;
        bh_wa = clr_idx;
      end
      S_POP_RD: begin
        nd_rd = 1'b1;
        nd_ra = alloc[NW-1:0];
      end
      S_WALK_RD: begin
        nd_rd = 1'b1;
      end
      S_PUT_NEW: begin
        nd_we = 1'b1;
        nd_wa = alloc[NW-1:0];
        nd_wd = {req.key, req.value_in, LinkNull};
        if (bh_q == LinkNull) begin
          bh_we = 1'b1;
          bh_wd = alloc;
        end
      end
      S_PUT_LINK: begin
        // old tail still sits in the read register
        nd_we = 1'b1;
        nd_wd = {n_key, n_val, alloc};
      end
      S_REM_PREV: begin
        if (prev == LinkNull) begin
          bh_we = 1'b1;
          bh_wd = n_next;
        end else begin
          nd_we = 1'b1;
          nd_wa = prev[NW-1:0];
          nd_wd = {prev_key, prev_val, n_next};
        end
      end
      S_REM_FREE: begin
        nd_we = 1'b1;
        nd_wd = {n_key, n_val, free_head};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_idx <= '0;
      free_head <= LinkNull;
      fresh <= '0;
    end else begin
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + BW'(1);
          if (clr_idx == LastBkt) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req <= in_data;
            bkt <= hash_bkt;
            state <= hash_done ? S_HEAD : S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            bkt <= hash_bkt;
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          prev <= LinkNull;
          cur <= bh_q;
          case (req.cmd)
            CMD_PUT: begin
              if (free_head != LinkNull) begin
                alloc <= free_head;
                state <= S_POP_RD;
              end else if (fresh != LinkNull) begin
                alloc <= fresh;
                fresh <= fresh + LinkW'(1);
                state <= (bh_q == LinkNull) ? S_PUT_NEW : S_WALK_RD;
              end else begin
                out_data <= '{status: ST_FULL, value_out: 32'd0};
                state <= S_OUT;
              end
            end
            CMD_GET, CMD_REMOVE: begin
              out_data <= '{status: ST_MISS, value_out: 32'd0};
              state <= (bh_q == LinkNull) ? S_OUT : S_WALK_RD;
            end
            default: begin
              out_data <= '{status: ST_MISS, value_out: 32'd0};
              state <= S_OUT;
            end
          endcase
        end
        S_POP_RD: begin
          state <= S_POP_DAT;
        end
        S_POP_DAT: begin
          free_head <= n_next;
          state <= (bh_q == LinkNull) ? S_PUT_NEW : S_WALK_RD;
        end
        S_WALK_RD: begin
          state <= S_WALK_DAT;
        end
        S_WALK_DAT: begin
          if (req.cmd == CMD_PUT) begin
            if (n_next == LinkNull) begin
              state <= S_PUT_NEW;
            end else begin
              cur <= n_next;
              state <= S_WALK_RD;
            end
          end else if (n_key == req.key) begin
            if (req.cmd == CMD_GET) begin
              out_data <= '{status: ST_OK, value_out: n_val};
              state <= S_OUT;
            end else begin
              state <= S_REM_PREV;
            end
          end else if (n_next == LinkNull) begin
            state <= S_OUT;
          end else begin
            prev <= cur;
            prev_key <= n_key;
            prev_val <= n_val;
            cur <= n_next;
            state <= S_WALK_RD;
          end
        end
        S_PUT_NEW: begin
          out_data <= '{status: ST_OK, value_out: 32'd0};
          state <= (bh_q == LinkNull) ? S_OUT : S_PUT_LINK;
        end
        S_PUT_LINK: begin
          state <= S_OUT;
        end
        S_REM_PREV: begin
          state <= S_REM_FREE;
        end
        S_REM_FREE: begin
          free_head <= cur;
          out_data <= '{status: ST_OK, value_out: 32'd0};
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/sv/tb_chained_hash_table_engine_top.sv
// testbench for chained_hash_table_engine_top: directed table, pool fill and drain, then random traffic
// checks every response against an in-bench hash table with node pool; needs chte_pkg and the rtl
module tb_chained_hash_table_engine_top;
  import chte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = 64;
  localparam int NP = 256;
  localparam int NIL = NP;
  localparam int RANDOM_ITEMS = 1300;
  localparam int LIMIT_CYCLES = 5000000;
  localparam logic [1:0] CMD_BAD = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  chained_hash_table_engine_top u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // shadow table
  int bucket_head[NB];
  logic [31:0] node_key[NP];
  logic [31:0] node_val[NP];
  int node_next[NP];
  int free_head;
  int fresh_count;

  rsp_t pending_rsp[$];
  int errors = 0;
  int cycles = 0;

  // keys drawn from a small pool so hits, duplicates and long chains happen
  logic [31:0] key_pool[16];

  function automatic int take_node();
    int n;
    if (free_head != NIL) begin
      n = free_head;
      free_head = node_next[n];
      return n;
    end
    if (fresh_count < NP) begin
      fresh_count++;
      return fresh_count - 1;
    end
    return NIL;
  endfunction

  function automatic rsp_t table_response(req_t r);
    rsp_t res;
    int b;
    int p;
    int prev;
    int n;
    res = '0;
    res.status = ST_MISS;
    b = int'(r.key % NB);
    p = bucket_head[b];
    prev = NIL;
    case (r.cmd)
      CMD_PUT: begin
        n = take_node();
        if (n == NIL) begin
          res.status = ST_FULL;
        end else begin
          node_key[n] = r.key;
          node_val[n] = r.value_in;
          node_next[n] = NIL;
          if (p == NIL) bucket_head[b] = n;
          else begin
            while (node_next[p] != NIL) p = node_next[p];
            node_next[p] = n;
          end
          res.status = ST_OK;
        end
      end
      CMD_GET: begin
        while (p != NIL) begin
          if (node_key[p] == r.key) begin
            res.status = ST_OK;
            res.value_out = node_val[p];
            break;
          end
          p = node_next[p];
        end
      end
      CMD_REMOVE: begin
        while (p != NIL) begin
          if (node_key[p] == r.key) begin
            if (prev != NIL) node_next[prev] = node_next[p];
            else bucket_head[b] = node_next[p];
            node_next[p] = free_head;
            free_head = p;
            res.status = ST_OK;
            break;
          end
          prev = p;
          p = node_next[p];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // drive one item, hold until accepted; a burst keeps valid high between items
  task automatic send_item(req_t r, bit keep_valid);
    rsp_t expd;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expd = table_response(r);
    pending_rsp.push_back(expd);
    if (!keep_valid) in_valid <= 1'b0;
  endtask

  // response checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected item status=%0d value=%h", $time, out_data.status,
                 out_data.value_out);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data.status);
        end
        if (out_data.value_out !== want.value_out) begin
          errors++;
          $display("%0t: value_out expected %h actual %h", $time, want.value_out,
                   out_data.value_out);
        end
      end
    end
  end

  // receiver stall pattern: quiet stretches, random stretches, heavy stretches
  always @(posedge clk) begin
    int phase;
    phase = (cycles / 3000) % 3;
    if (phase == 0) out_stall <= 1'b0;
    else if (phase == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // directed rows; has_want marks rows whose response is obvious
  typedef struct {
    req_t r;
    bit   has_want;
    rsp_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic dir_row_t mk_row(logic [1:0] c, logic [31:0] k, logic [31:0] v,
                                      bit hw, logic [1:0] st, logic [31:0] vo);
    dir_row_t d;
    d.r.cmd = c;
    d.r.key = k;
    d.r.value_in = v;
    d.has_want = hw;
    d.want.status = st;
    d.want.value_out = vo;
    return d;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) r.cmd = CMD_PUT;
    else if (sel < 75) r.cmd = CMD_GET;
    else if (sel < 97) r.cmd = CMD_REMOVE;
    else r.cmd = CMD_BAD;
    if ($urandom_range(0, 9) == 0) r.key = $urandom();
    else r.key = key_pool[$urandom_range(0, 15)];
    r.value_in = $urandom();
    return r;
  endfunction

  initial begin
    rsp_t got;
    int burst;
    int sent;
    int i;
    for (i = 0; i < NB; i++) bucket_head[i] = NIL;
    for (i = 0; i < NP; i++) node_next[i] = NIL;
    free_head = NIL;
    fresh_count = 0;
    for (i = 0; i < 16; i++) key_pool[i] = (i < 8) ? ($urandom() & ~32'h3f) | 32'd5 : $urandom();
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hffff_ffff;

    dir_rows.push_back(mk_row(CMD_GET, 32'h0, 32'h0, 1, ST_MISS, 32'h0));
    dir_rows.push_back(mk_row(CMD_REMOVE, 32'hffff_ffff, 32'h0, 1, ST_MISS, 32'h0));
    dir_rows.push_back(mk_row(CMD_BAD, 32'h1234, 32'hffff_ffff, 1, ST_MISS, 32'h0));
    dir_rows.push_back(mk_row(CMD_PUT, 32'h0, 32'hffff_ffff, 1, ST_OK, 32'h0));
    dir_rows.push_back(mk_row(CMD_PUT, 32'hffff_ffff, 32'h0, 1, ST_OK, 32'h0));
    dir_rows.push_back(mk_row(CMD_GET, 32'h0, 32'h0, 1, ST_OK, 32'hffff_ffff));
    dir_rows.push_back(mk_row(CMD_GET, 32'hffff_ffff, 32'hffff_ffff, 1, ST_OK, 32'h0));
    // same bucket as key 0, and a duplicate of key 0 behind it
    dir_rows.push_back(mk_row(CMD_PUT, 32'h40, 32'haaaa_5555, 0, ST_OK, 32'h0));
    dir_rows.push_back(mk_row(CMD_PUT, 32'h0, 32'h5555_aaaa, 0, ST_OK, 32'h0));
    dir_rows.push_back(mk_row(CMD_GET, 32'h0, 32'h0, 0, ST_OK, 32'h0));
    dir_rows.push_back(mk_row(CMD_REMOVE, 32'h0, 32'h0, 0, ST_OK, 32'h0));
    dir_rows.push_back(mk_row(CMD_GET, 32'h0, 32'h0, 0, ST_OK, 32'h0));
    dir_rows.push_back(mk_row(CMD_REMOVE, 32'h40, 32'h0, 0, ST_OK, 32'h0));
    dir_rows.push_back(mk_row(CMD_GET, 32'h40, 32'h0, 1, ST_MISS, 32'h0));
    // recycled nodes go out first
    dir_rows.push_back(mk_row(CMD_PUT, 32'h8000_0001, 32'h1, 0, ST_OK, 32'h0));
    dir_rows.push_back(mk_row(CMD_GET, 32'h8000_0001, 32'h0, 1, ST_OK, 32'h1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[j]) begin
      send_item(dir_rows[j].r, 1'b1);
      if (dir_rows[j].has_want) begin
        got = pending_rsp[pending_rsp.size() - 1];
        if (got !== dir_rows[j].want) begin
          errors++;
          $display("%0t: table row %0d expected %h actual %h", $time, j,
                   dir_rows[j].want, got);
        end
      end
    end

    // fill the pool to the brim and beyond, then drain some of it
    for (i = 0; i < NP + 4; i++) begin
      req_t r;
      r.cmd = CMD_PUT;
      r.key = key_pool[i % 16];
      r.value_in = $urandom();
      send_item(r, 1'b1);
    end
    for (i = 0; i < NP / 2; i++) begin
      req_t r;
      r.cmd = CMD_REMOVE;
      r.key = key_pool[$urandom_range(0, 15)];
      r.value_in = $urandom();
      send_item(r, i != NP / 2 - 1);
    end

    // hold off until the block has caught up
    while (pending_rsp.size() != 0) @(posedge clk);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && sent < RANDOM_ITEMS) begin
        send_item(rand_req(), burst > 1 && sent < RANDOM_ITEMS - 1);
        burst--;
        sent++;
      end
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/chte_pkg.sv
hw/rtl/chte_bucket_ram.sv
hw/rtl/chte_node_ram.sv
hw/rtl/chained_hash_table_engine_top.sv
tb/sv/tb_chained_hash_table_engine_top.sv
